/* hw/rtl/sida_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII block.
`default_nettype none

package sida_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned MIN_DIG_W   = 7;
  localparam int unsigned PREC_W      = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned STEP_W      = 6;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [PREC_W-1:0] MAX_PRECISION = 6'd62;
  localparam logic [PREC_W-1:0] DEFAULT_PREC  = 6'd1;
  localparam logic [STEP_W-1:0] LAST_STEP     = 6'd63;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/sida_cell.sv */
// One BCD digit cell: add-3 and shift for conversion, digit shift for readout.
`default_nettype none

module sida_cell (
  input  logic                                clk_i,
  input  sida_pkg::cell_op_e                  op_i,
  input  logic                                bit_i,
  input  logic [sida_pkg::DIGIT_W-1:0]        digit_i,
  output logic [sida_pkg::DIGIT_W-1:0]        digit_o
);
  import sida_pkg::*;

  logic [DIGIT_W-1:0] digit_q;
  logic [DIGIT_W-1:0] digit_d;
  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_q >= DABBLE_LIMIT) ? digit_q + DABBLE_ADD : digit_q;
    unique case (op_i)
      CELL_CLEAR:  digit_d = '0;
      CELL_DABBLE: digit_d = {adj[DIGIT_W-2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

/* hw/rtl/sida_chain.sv */
// Row of BCD digit cells, least significant digit in cell zero.
`default_nettype none

module sida_chain #(
  parameter int unsigned NumCells = 19
) (
  input  logic                                clk_i,
  input  sida_pkg::cell_op_e                  op_i,
  input  logic                                bit_i,
  output logic [sida_pkg::DIGIT_W-1:0]        top_digit_o
);
  import sida_pkg::*;

  logic [DIGIT_W-1:0] digit [NumCells];

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    logic               cell_bit;
    logic [DIGIT_W-1:0] cell_din;

    if (k == 0) begin : g_first
      assign cell_bit = bit_i;
      assign cell_din = '0;
    end else begin : g_rest
      assign cell_bit = (digit[k-1] >= DABBLE_LIMIT);
      assign cell_din = digit[k-1];
    end

    sida_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .bit_i   (cell_bit),
      .digit_i (cell_din),
      .digit_o (digit[k])
    );
  end

  assign top_digit_o = digit[NumCells-1];

endmodule

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed 64-bit integer to printf %d style decimal ASCII text.
//
//   channel  dir  tdata                                  tuser                       tlast
//   s_axis   in   [63:0] value, [70:64] min_digits        [0] force_plus,            -
//                                                         [1] space_for_plus
//   m_axis   out  [7:0] out_char, [13:8] text_length      [0] empty_text             last_char
//
// An item is accepted, run through the add-3/shift steps in the cell row, stripped
// of leading zero digits off the top cell, and then emitted at one character per cycle
// (0 to 63 characters) while m_axis_tready_i stays high.
// Reset clears control state; digit cells hold no value until the first conversion.
// m_axis_tready_i low while m_axis_tvalid_o is high holds the output register and pauses emission.
// s_axis_tready_o is high only while no conversion is in flight.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned MAX_DIGITS = 19
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [63:0] value, [70:64] min_digits, [71] zero
  input  logic [sida_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  // [0] force_plus, [1] space_for_plus
  input  logic [sida_pkg::IN_USER_W-1:0]        s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [7:0] out_char, [13:8] text_length, [15:14] zero
  output logic [sida_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // [0] empty_text
  output logic [0:0]                            m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);
  import sida_pkg::*;

  localparam int unsigned NdW = $clog2(MAX_DIGITS + 1);

  state_e               state_q, state_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [PREC_W-1:0]    prec_q, prec_d;
  logic                 sign_pend_q, sign_pend_d;
  logic [CHAR_W-1:0]    sign_char_q, sign_char_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [NdW-1:0]       nd_q, nd_d;
  logic [PREC_W-1:0]    pad_q, pad_d;
  logic [LEN_W-1:0]     len_q, len_d;

  logic                 m_valid_q, m_valid_d;
  logic [CHAR_W-1:0]    m_char_q, m_char_d;
  logic                 m_last_q, m_last_d;
  logic                 m_empty_q, m_empty_d;
  logic [LEN_W-1:0]     m_len_q, m_len_d;

  cell_op_e             cell_op;
  logic [DIGIT_W-1:0]   top_digit;

  logic [VALUE_W-1:0]   in_value;
  logic [MIN_DIG_W-1:0] in_min_dig;
  logic                 in_neg;
  logic                 out_free;
  logic                 more_left;
  logic [PREC_W-1:0]    nd_ext;

  assign in_value   = s_axis_tdata_i[VALUE_W-1:0];
  assign in_min_dig = s_axis_tdata_i[VALUE_W +: MIN_DIG_W];
  assign in_neg     = in_value[VALUE_W-1];
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign nd_ext     = PREC_W'(nd_q);

  sida_chain #(
    .NumCells (MAX_DIGITS)
  ) u_chain (
    .clk_i       (clk_i),
    .op_i        (cell_op),
    .bit_i       (mag_q[VALUE_W-1]),
    .top_digit_o (top_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_pend_q <= 1'b0;
      step_q      <= '0;
      nd_q        <= '0;
      pad_q       <= '0;
      len_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      sign_pend_q <= sign_pend_d;
      step_q      <= step_d;
      nd_q        <= nd_d;
      pad_q       <= pad_d;
      len_q       <= len_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    prec_q      <= prec_d;
    sign_char_q <= sign_char_d;
    m_char_q    <= m_char_d;
    m_last_q    <= m_last_d;
    m_empty_q   <= m_empty_d;
    m_len_q     <= m_len_d;
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    prec_d      = prec_q;
    sign_pend_d = sign_pend_q;
    sign_char_d = sign_char_q;
    step_d      = step_q;
    nd_d        = nd_q;
    pad_d       = pad_q;
    len_d       = len_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_char_d    = m_char_q;
    m_last_d    = m_last_q;
    m_empty_d   = m_empty_q;
    m_len_d     = m_len_q;
    cell_op     = CELL_HOLD;
    more_left   = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          mag_d   = in_neg ? (~in_value + VALUE_W'(1)) : in_value;
          cell_op = CELL_CLEAR;
          step_d  = '0;
          if (in_min_dig[MIN_DIG_W-1]) begin
            prec_d = DEFAULT_PREC;
          end else if (in_min_dig[PREC_W-1:0] > MAX_PRECISION) begin
            prec_d = MAX_PRECISION;
          end else begin
            prec_d = in_min_dig[PREC_W-1:0];
          end
          sign_pend_d = 1'b1;
          if (in_neg) begin
            sign_char_d = CHAR_MINUS;
          end else if (s_axis_tuser_i[0]) begin
            sign_char_d = CHAR_PLUS;
          end else if (s_axis_tuser_i[1]) begin
            sign_char_d = CHAR_SPACE;
          end else begin
            sign_char_d = CHAR_NONE;
            sign_pend_d = 1'b0;
          end
          state_d = ST_CONV;
        end
      end

      ST_CONV: begin
        cell_op = CELL_DABBLE;
        mag_d   = {mag_q[VALUE_W-2:0], 1'b0};
        step_d  = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          nd_d    = NdW'(MAX_DIGITS);
          state_d = ST_NORM;
        end
      end

      ST_NORM: begin
        if (nd_q != '0 && top_digit == '0) begin
          cell_op = CELL_SHIFT;
          nd_d    = nd_q - NdW'(1);
        end else begin
          pad_d   = (prec_q > nd_ext) ? prec_q - nd_ext : '0;
          len_d   = '0;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_empty_d = 1'b0;
          if (!sign_pend_q && pad_q == '0 && nd_q == '0) begin
            m_char_d  = CHAR_NONE;
            m_last_d  = 1'b1;
            m_empty_d = 1'b1;
            m_len_d   = '0;
            state_d   = ST_IDLE;
          end else begin
            if (sign_pend_q) begin
              m_char_d    = sign_char_q;
              sign_pend_d = 1'b0;
              more_left   = (pad_q != '0) || (nd_q != '0);
            end else if (pad_q != '0) begin
              m_char_d  = CHAR_ZERO;
              pad_d     = pad_q - PREC_W'(1);
              more_left = (pad_q != PREC_W'(1)) || (nd_q != '0);
            end else begin
              m_char_d  = CHAR_ZERO + CHAR_W'(top_digit);
              cell_op   = CELL_SHIFT;
              nd_d      = nd_q - NdW'(1);
              more_left = (nd_q != NdW'(1));
            end
            len_d    = len_q + LEN_W'(1);
            m_last_d = !more_left;
            m_len_d  = more_left ? '0 : len_q + LEN_W'(1);
            if (!more_left) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_len_q, m_char_q};
  assign m_axis_tuser_o  = m_empty_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

/* hw/rtl/sida_checker.sv */
// Port-level checks for the decimal ASCII formatter, bound to the top level.
`default_nettype none

module sida_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  input  logic                                  s_axis_tready_o,
  input  logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  input  logic [sida_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  input  logic [0:0]                            m_axis_tuser_o,
  input  logic                                  m_axis_tlast_o
);
  import sida_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      m_axis_tlast_o && m_axis_tdata_o == '0)
    else $error("empty result not final or carries data");

  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[CHAR_W +: LEN_W] == '0)
    else $error("length shown on non-final result");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tuser_o[0] |->
      m_axis_tdata_o[CHAR_W +: LEN_W] != '0)
    else $error("final character with zero length");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again before conversion ran");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
